[hw/rtl/pli_pkg.sv]
package pli_pkg;

  localparam int MaxEntries = 16;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int TempW      = 16;
  localparam int ValW       = 16;
  localparam int CountW     = 5;

  // Stream and configuration port widths.
  localparam int InDataW    = 56;
  localparam int OutDataW   = 24;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 5;

  // Datapath widths.
  localparam int DiffW      = TempW + 1;
  localparam int ProdW      = 2 * DiffW;
  localparam int DenW       = TempW;
  localparam int DivSteps   = 17;
  localparam int RemW       = TempW + DivSteps;
  localparam int SumW       = DivSteps + 3;

  localparam int UnitOne    = 16384;
  localparam int ValMax     = 32767;
  localparam int ValMin     = -32768;

  typedef enum logic {
    OpWrite = 1'b0,
    OpEval  = 1'b1
  } op_t;

  localparam logic [1:0] StInside = 2'd0;
  localparam logic [1:0] StBelow  = 2'd1;
  localparam logic [1:0] StAbove  = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgEntryCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgClampUnit  = 1'b1;

  // One word in flight through the divider.
  typedef struct packed {
    logic [RemW-1:0]     rem;
    logic [DenW-1:0]     den;
    logic [DivSteps-1:0] quot;
    logic                ovf;
    logic                neg;
    logic                degen;
    logic [1:0]          status;
    logic [ValW-1:0]     y1;
  } pli_div_t;

endpackage

[hw/rtl/pli_div.sv]
module pli_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  pli_pkg::pli_div_t din,
  output logic              out_valid,
  output pli_pkg::pli_div_t dout
);
  import pli_pkg::*;

  // Restoring divider, one quotient bit per stage, most significant bit first.
  // A dividend at or above den << DivSteps is flagged in ovf before it enters, so DivSteps bits suffice.
  pli_div_t            stg [DivSteps];
  logic [DivSteps-1:0] vld;

  for (genvar j = 0; j < DivSteps; j++) begin : g_step
    localparam int StepBit = DivSteps - 1 - j;
    pli_div_t        src;
    pli_div_t        stg_next;
    logic [RemW-1:0] trial;

    if (j == 0) begin : g_first
      assign src = din;
    end else begin : g_rest
      assign src = stg[j-1];
    end

    always_comb begin
      trial    = RemW'(src.den) << StepBit;
      stg_next = src;
      if (src.rem >= trial) begin
        stg_next.rem           = src.rem - trial;
        stg_next.quot[StepBit] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[j] <= stg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DivSteps-2:0], in_valid};
    end
  end

  assign dout      = stg[DivSteps-1];
  assign out_valid = vld[DivSteps-1];

endmodule

[hw/rtl/piecewise_linear_interpolator_core.sv]
// Piecewise linear interpolation over a table of up to 16 breakpoints.
// Input words arrive on s_axis. tuser selects the kind of word: a write word
// loads one breakpoint (temperature and value) into the slot given by its
// index, and an evaluate word asks for the interpolated value at its query
// temperature. Only evaluate words produce an output word on m_axis.
// A write takes effect at the edge where it is accepted; any word accepted
// after it sees the new entry.
// The pipeline takes one word per cycle while the output is not stalled. The
// edge that accepts an evaluate word loads the query register; then come the
// table read, three arithmetic stages, a 17-stage restoring divider (one
// quotient bit per stage) and the output register.
// The configuration port writes entry_count and clamp_unit; write them only
// while no evaluate word is in flight.
// Reset clears all valid bits and sets entry_count to 2 and clamp_unit to 1.
// Table contents are not cleared and must be written before they are used.
// When the receiver holds m_axis_tready low with a word waiting, the whole
// pipeline stops and s_axis_tready drops until the word is taken.
module piecewise_linear_interpolator_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // entry_index[3:0], entry_temperature[19:4], entry_value[35:20],
  // query_temperature[51:36], zero fill[55:52]
  input  logic [pli_pkg::InDataW-1:0]     s_axis_tdata,
  // operation[0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // result_value[15:0], range_status[17:16], degenerate_segment[18],
  // zero fill[23:19]
  output logic [pli_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [pli_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [pli_pkg::CfgDataW-1:0]    cfg_data
);
  import pli_pkg::*;

  logic              advance;
  logic              accept;
  op_t               in_op;
  logic [IdxW-1:0]   in_idx;
  logic [TempW-1:0]  in_temp;
  logic [ValW-1:0]   in_val;
  logic [TempW-1:0]  in_query;

  logic [CountW-1:0] entry_count;
  logic              clamp_unit;

  logic [TempW-1:0]      temp_ff [MaxEntries];
  logic [ValW+TempW-1:0] tbl_mem [MaxEntries];

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid && advance;

  assign in_op    = op_t'(s_axis_tuser);
  assign in_idx   = s_axis_tdata[3:0];
  assign in_temp  = s_axis_tdata[19:4];
  assign in_val   = s_axis_tdata[35:20];
  assign in_query = s_axis_tdata[51:36];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= CountW'(2);
      clamp_unit  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgEntryCount: entry_count <= cfg_data;
        CfgClampUnit:  clamp_unit  <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // The comparators need every temperature at once, so the temperatures are
  // kept in flops as well as in the table memory.
  always_ff @(posedge clk) begin
    if (accept && in_op == OpWrite) begin
      temp_ff[in_idx] <= in_temp;
      tbl_mem[in_idx] <= {in_val, in_temp};
    end
  end

  // Stage 1: query register.
  logic             s1_valid;
  logic [TempW-1:0] s1_query;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept && in_op == OpEval;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_query <= in_query;
    end
  end

  // Segment search against all breakpoints in parallel.
  logic [MaxEntries-1:0] ge;
  logic [IdxW-1:0]       n_m1;
  logic [IdxW-1:0]       first;
  logic [IdxW-1:0]       addr_hi;
  logic [IdxW-1:0]       addr_lo;
  logic                  below;
  logic                  above;
  logic [1:0]            status_next;

  always_comb begin
    if (entry_count < CountW'(2)) begin
      n_m1 = IdxW'(1);
    end else if (entry_count > CountW'(MaxEntries)) begin
      n_m1 = IdxW'(MaxEntries - 1);
    end else begin
      n_m1 = IdxW'(entry_count - CountW'(1));
    end
    for (int k = 0; k < MaxEntries; k++) begin
      ge[k] = temp_ff[k] >= s1_query;
    end
    first = '0;
    for (int k = MaxEntries - 1; k >= 0; k--) begin
      if (ge[k]) begin
        first = IdxW'(k);
      end
    end
    below = temp_ff[0] > s1_query;
    above = !ge[n_m1];
    // Below the table wins over above it when the table is unsorted.
    priority if (below) begin
      addr_hi     = IdxW'(1);
      status_next = StBelow;
    end else if (above) begin
      addr_hi     = n_m1;
      status_next = StAbove;
    end else if (first == '0) begin
      addr_hi     = IdxW'(1);
      status_next = StInside;
    end else begin
      addr_hi     = first;
      status_next = StInside;
    end
    addr_lo = addr_hi - IdxW'(1);
  end

  // Stage 2: both segment ends read from the table.
  logic                  s2_valid;
  logic [TempW-1:0]      s2_query;
  logic [1:0]            s2_status;
  logic [ValW+TempW-1:0] rd_lo;
  logic [ValW+TempW-1:0] rd_hi;

  always_ff @(posedge clk) begin
    if (advance) begin
      rd_lo <= tbl_mem[addr_lo];
      rd_hi <= tbl_mem[addr_hi];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_query  <= s1_query;
      s2_status <= status_next;
    end
  end

  logic [TempW-1:0]        x1;
  logic [TempW-1:0]        x2;
  logic [ValW-1:0]         y1;
  logic [ValW-1:0]         y2;
  logic signed [DiffW-1:0] dt_next;
  logic signed [DiffW-1:0] dy_next;
  logic signed [DiffW-1:0] dq_next;

  assign x1      = rd_lo[TempW-1:0];
  assign y1      = rd_lo[ValW+TempW-1:TempW];
  assign x2      = rd_hi[TempW-1:0];
  assign y2      = rd_hi[ValW+TempW-1:TempW];
  assign dt_next = $signed({1'b0, x2}) - $signed({1'b0, x1});
  assign dy_next = $signed({y2[ValW-1], y2}) - $signed({y1[ValW-1], y1});
  assign dq_next = $signed({1'b0, s2_query}) - $signed({1'b0, x1});

  // Stage 3: differences.
  logic                    s3_valid;
  logic signed [DiffW-1:0] s3_dt;
  logic signed [DiffW-1:0] s3_dy;
  logic signed [DiffW-1:0] s3_dq;
  logic [ValW-1:0]         s3_y1;
  logic [1:0]              s3_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_dt     <= dt_next;
      s3_dy     <= dy_next;
      s3_dq     <= dq_next;
      s3_y1     <= y1;
      s3_status <= s2_status;
    end
  end

  logic signed [ProdW-1:0] prod_next;
  logic [DiffW-1:0]        dt_mag;

  assign prod_next = ProdW'(s3_dy) * ProdW'(s3_dq);
  assign dt_mag    = s3_dt[DiffW-1] ? -s3_dt : s3_dt;

  // Stage 4: product and divisor magnitude.
  logic                    s4_valid;
  logic signed [ProdW-1:0] s4_prod;
  logic [DenW-1:0]         s4_ad;
  logic                    s4_dtneg;
  logic                    s4_degen;
  logic [ValW-1:0]         s4_y1;
  logic [1:0]              s4_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (advance) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_prod   <= prod_next;
      s4_ad     <= dt_mag[DenW-1:0];
      s4_dtneg  <= s3_dt[DiffW-1];
      s4_degen  <= s3_dt == '0;
      s4_y1     <= s3_y1;
      s4_status <= s3_status;
    end
  end

  // Rounding adds half the divisor before a truncating divide. A quotient
  // that would not fit saturates the result anyway, so it is flagged here.
  logic [ProdW-1:0] prod_mag;
  logic [RemW-1:0]  num;
  pli_div_t         div_in_next;

  always_comb begin
    prod_mag               = s4_prod[ProdW-1] ? -s4_prod : s4_prod;
    num                    = prod_mag[RemW-1:0] + RemW'(s4_ad >> 1);
    div_in_next.rem        = num;
    div_in_next.den        = s4_ad;
    div_in_next.quot       = '0;
    div_in_next.ovf        = num >= (RemW'(s4_ad) << DivSteps);
    div_in_next.neg        = s4_prod[ProdW-1] ^ s4_dtneg;
    div_in_next.degen      = s4_degen;
    div_in_next.status     = s4_status;
    div_in_next.y1         = s4_y1;
  end

  // Stage 5: divider input register.
  logic     div_in_valid;
  pli_div_t div_in;
  logic     div_out_valid;
  pli_div_t div_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_in_valid <= 1'b0;
    end else if (advance) begin
      div_in_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      div_in <= div_in_next;
    end
  end

  pli_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (div_in_valid),
    .din       (div_in),
    .out_valid (div_out_valid),
    .dout      (div_out)
  );

  // Sign, base value and final limit.
  logic [DivSteps:0]      qmag;
  logic signed [SumW-1:0] q_signed;
  logic signed [SumW-1:0] v_sum;
  logic [ValW-1:0]        res_next;

  always_comb begin
    qmag     = div_out.ovf ? (DivSteps+1)'(1) << DivSteps : {1'b0, div_out.quot};
    q_signed = div_out.neg ? -$signed(SumW'(qmag)) : $signed(SumW'(qmag));
    if (div_out.degen) begin
      v_sum = '0;
    end else begin
      v_sum = SumW'($signed(div_out.y1)) + q_signed;
    end
    if (clamp_unit) begin
      priority if (v_sum < 0) begin
        res_next = '0;
      end else if (v_sum > SumW'(UnitOne)) begin
        res_next = ValW'(UnitOne);
      end else begin
        res_next = v_sum[ValW-1:0];
      end
    end else begin
      priority if (v_sum < SumW'(ValMin)) begin
        res_next = ValW'(ValMin);
      end else if (v_sum > SumW'(ValMax)) begin
        res_next = ValW'(ValMax);
      end else begin
        res_next = v_sum[ValW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {5'b0, div_out.degen, div_out.status, res_next};
    end
  end

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && in_op == OpWrite) |=> !s1_valid)
    else $error("write word entered the result pipeline");

  a_segment_upper: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (addr_hi != '0 && addr_lo == addr_hi - IdxW'(1)))
    else $error("segment upper end selects the first breakpoint");

  a_below_first_segment: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && below) |-> (addr_hi == IdxW'(1) && status_next == StBelow))
    else $error("query below the table did not take the first segment");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[18]) |-> m_axis_tdata[15:0] == '0)
    else $error("degenerate segment with nonzero result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[17:16] == StInside ||
                       m_axis_tdata[17:16] == StBelow ||
                       m_axis_tdata[17:16] == StAbove))
    else $error("range status out of range");

endmodule

[bench/piecewise_linear_interpolator_core_test.sv]
module piecewise_linear_interpolator_core_test;
  import pli_pkg::*;

  localparam int PipeLatency   = 22;
  localparam int DrainCycles   = PipeLatency + 12;
  localparam int HoldCycles    = 400;
  localparam int RandomWords   = 1000;
  localparam int TimeoutCycles = 600000;
  localparam int MaxReports    = 30;
  localparam int NumDirRows    = 25;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic [1:0]      status;
    logic            degen;
  } interp_t;

  typedef enum logic [1:0] {
    RowWrite,
    RowEval,
    RowClamp
  } row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [IdxW-1:0]  idx;
    logic [TempW-1:0] temp;
    logic [ValW-1:0]  val;
    logic [TempW-1:0] query;
    logic             typed;
    interp_t          want;
  } dir_row_t;

  localparam interp_t NoWant = '0;

  // Eval rows with typed set carry their expected word; the others go through
  // the predictor. A clamp row writes clamp_unit with the value column.
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{RowWrite, 4'd0, 16'd1600,  16'sd0,      16'd0,     1'b0, NoWant},
    '{RowWrite, 4'd1, 16'd3200,  16'sd16384,  16'd0,     1'b0, NoWant},
    // Reset settings: two breakpoints, result clamped to 0..1.
    '{RowEval,  4'd0, 16'd0,     16'sd0,      16'd1600,  1'b1, '{16'sd0, StInside, 1'b0}},
    '{RowEval,  4'd0, 16'd0,     16'sd0,      16'd3200,  1'b1, '{16'sd16384, StInside, 1'b0}},
    '{RowEval,  4'd0, 16'd0,     16'sd0,      16'd2400,  1'b1, '{16'sd8192, StInside, 1'b0}},
    '{RowEval,  4'd0, 16'd0,     16'sd0,      16'd0,     1'b1, '{16'sd0, StBelow, 1'b0}},
    '{RowEval,  4'd0, 16'd0,     16'sd0,      16'd65535, 1'b1, '{16'sd16384, StAbove, 1'b0}},
    '{RowClamp, 4'd0, 16'd0,     16'sd0,      16'd0,     1'b0, NoWant},
    // Clamping off: extrapolation below the table and saturation above it.
    '{RowEval,  4'd0, 16'd0,     16'sd0,      16'd0,     1'b1, '{-16'sd16384, StBelow, 1'b0}},
    '{RowEval,  4'd0, 16'd0,     16'sd0,      16'd65535, 1'b1, '{16'sd32767, StAbove, 1'b0}},
    // Zero-width segment, inside and beyond the table.
    '{RowWrite, 4'd1, 16'd1600,  16'sd100,    16'd0,     1'b0, NoWant},
    '{RowEval,  4'd0, 16'd0,     16'sd0,      16'd1600,  1'b1, '{16'sd0, StInside, 1'b1}},
    '{RowEval,  4'd0, 16'd0,     16'sd0,      16'd5000,  1'b1, '{16'sd0, StAbove, 1'b1}},
    // Full span of temperature and value.
    '{RowWrite, 4'd0, 16'd0,     16'sh8000,   16'd0,     1'b0, NoWant},
    '{RowWrite, 4'd1, 16'd65535, 16'sd32767,  16'd0,     1'b0, NoWant},
    '{RowEval,  4'd0, 16'd0,     16'sd0,      16'd0,     1'b1, '{16'sh8000, StInside, 1'b0}},
    '{RowEval,  4'd0, 16'd0,     16'sd0,      16'd65535, 1'b1, '{16'sd32767, StInside, 1'b0}},
    '{RowEval,  4'd0, 16'd0,     16'sd0,      16'd32768, 1'b0, NoWant},
    // Descending table, so the segment has a negative width.
    '{RowWrite, 4'd0, 16'd5000,  16'sd1000,   16'd0,     1'b0, NoWant},
    '{RowWrite, 4'd1, 16'd1000,  -16'sd1000,  16'd0,     1'b0, NoWant},
    '{RowEval,  4'd0, 16'd0,     16'sd0,      16'd3000,  1'b0, NoWant},
    '{RowEval,  4'd0, 16'd0,     16'sd0,      16'd6000,  1'b0, NoWant},
    // A half step rounds away from zero.
    '{RowWrite, 4'd0, 16'd0,     16'sd0,      16'd0,     1'b0, NoWant},
    '{RowWrite, 4'd1, 16'd2,     -16'sd1,     16'd0,     1'b0, NoWant},
    '{RowEval,  4'd0, 16'd0,     16'sd0,      16'd1,     1'b1, '{-16'sd1, StInside, 1'b0}}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Predictor copy of the table and of the registers.
  logic [TempW-1:0]       lut_temp [MaxEntries];
  logic signed [ValW-1:0] lut_val [MaxEntries];
  logic [CountW-1:0]      cur_count;
  logic                   cur_clamp;
  interp_t                pending_results [$];

  int errors, words_sent, evals_sent, writes_sent, results_checked;
  int below_seen, above_seen, degen_seen, input_stalls, phases_run;
  int hold_asked, hold_taken, hold_left, stall_left;
  bit tx_burst, rx_eager;

  piecewise_linear_interpolator_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MaxReports) $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic interp_t interpolate(logic [TempW-1:0] q);
    interp_t r;
    int n, p, k;
    bit found;
    longint x1, dt, num, an, ad, mag, v;
    n = int'(cur_count);
    if (n < 2) n = 2;
    if (n > MaxEntries) n = MaxEntries;
    r.degen = 1'b0;
    if (q < lut_temp[0]) begin
      p = 1;
      r.status = StBelow;
    end else if (q > lut_temp[n-1]) begin
      p = n - 1;
      r.status = StAbove;
    end else begin
      p = n - 1;
      found = 1'b0;
      for (k = 0; k < n; k++) begin
        if (!found && lut_temp[k] >= q) begin
          p = k;
          found = 1'b1;
        end
      end
      if (p == 0) p = 1;
      r.status = StInside;
    end
    x1 = longint'(lut_temp[p-1]);
    dt = longint'(lut_temp[p]) - x1;
    if (dt == 0) begin
      v = 0;
      r.degen = 1'b1;
    end else begin
      num = (longint'(lut_val[p]) - longint'(lut_val[p-1])) * (longint'(q) - x1);
      an = (num < 0) ? -num : num;
      ad = (dt < 0) ? -dt : dt;
      mag = (an + ad / 2) / ad;
      v = longint'(lut_val[p-1]) + (((num < 0) != (dt < 0)) ? -mag : mag);
    end
    if (cur_clamp) begin
      if (v < 0) v = 0;
      if (v > UnitOne) v = UnitOne;
    end else begin
      if (v < ValMin) v = ValMin;
      if (v > ValMax) v = ValMax;
    end
    r.value = v[ValW-1:0];
    return r;
  endfunction

  // Offers one word, updates the predictor when it is taken, then maybe idles.
  task automatic send_word(op_t op, logic [IdxW-1:0] idx, logic [TempW-1:0] temp,
                           logic [ValW-1:0] val, logic [TempW-1:0] query,
                           bit typed, interp_t want);
    int gap, r;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= InDataW'({query, val, temp, idx});
    @(posedge clk);
    while (!s_axis_tready) begin
      input_stalls++;
      @(posedge clk);
    end
    words_sent++;
    if (op == OpWrite) begin
      lut_temp[idx] = temp;
      lut_val[idx]  = val;
      writes_sent++;
    end else begin
      pending_results.push_back(typed ? want : interpolate(query));
      evals_sent++;
    end
    r = $urandom_range(0, 99);
    if (tx_burst || r < 50) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write words make no result, so the bench waits for every expected result
  // and then idles for DrainCycles before the registers may change.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgEntryCount) cur_count = data;
    else cur_clamp = data[0];
    @(posedge clk);
  endtask

  // One setting of the registers: load a fresh table, then mostly evaluate.
  task automatic run_phase(int phase);
    int n, style, span, step, t, lo, hi, evals, r, k, swap;
    logic [CfgDataW-1:0] count_raw;
    logic [ValW-1:0] v;
    bit narrow;
    wait_idle();
    r = $urandom_range(0, 19);
    case (r)
      0: count_raw = CfgDataW'(0);
      1: count_raw = CfgDataW'(1);
      2: count_raw = CfgDataW'(17);
      3: count_raw = CfgDataW'(31);
      4, 5, 6: count_raw = CfgDataW'(MaxEntries);
      7: count_raw = CfgDataW'(2);
      default: count_raw = CfgDataW'($urandom_range(2, MaxEntries));
    endcase
    if (phase == 0 || phase == 2) count_raw = CfgDataW'(MaxEntries);
    if (phase == 1) count_raw = CfgDataW'(0);
    set_register(CfgEntryCount, count_raw);
    set_register(CfgClampUnit, (phase < 2) ? CfgDataW'(phase[0]) : CfgDataW'($urandom_range(0, 1)));
    n = (count_raw < 2) ? 2 : (count_raw > MaxEntries) ? MaxEntries : int'(count_raw);
    rx_eager = ($urandom_range(0, 3) == 0);
    tx_burst = ($urandom_range(0, 3) == 0);
    if (phase == 2) begin
      rx_eager = 1'b0;
      tx_burst = 1'b1;
    end

    style  = $urandom_range(0, 9);
    narrow = 1'($urandom_range(0, 1));
    t      = $urandom_range(0, 3000);
    span   = (65535 - t) / n;
    for (k = 0; k < n; k++) begin
      if (style == 9) t = (k * 65535) / (n - 1);
      else if (style == 8) t = $urandom_range(0, 65535);
      else if (k > 0) begin
        if (style >= 6 && $urandom_range(0, 3) == 0) step = 0;
        else step = $urandom_range(1, span);
        t += step;
      end
      if (style == 9) v = k[0] ? 16'h7FFF : 16'h8000;
      else if (narrow) v = ValW'($urandom_range(0, 20000) - 2000);
      else v = ValW'($urandom);
      send_word(OpWrite, k[IdxW-1:0], t[TempW-1:0], v, TempW'($urandom), 1'b0, NoWant);
    end

    // In phase 2 the receiver holds off while the sender keeps pushing evaluate words.
    if (phase == 2) hold_asked++;
    evals = (phase == 2) ? 120 : $urandom_range(30, 80);
    for (k = 0; k < evals; k++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_word(OpWrite, IdxW'($urandom), TempW'($urandom), ValW'($urandom),
                  TempW'($urandom), 1'b0, NoWant);
      end else begin
        lo = int'(lut_temp[0]);
        hi = int'(lut_temp[n-1]);
        if (lo > hi) begin
          swap = lo;
          lo = hi;
          hi = swap;
        end
        if (r < 45) t = $urandom_range(lo, hi);
        else if (r < 60) t = lut_temp[$urandom_range(0, n - 1)] + $urandom_range(0, 2) - 1;
        else if (r < 70) t = lo - $urandom_range(0, 300);
        else if (r < 80) t = hi + $urandom_range(0, 300);
        else if (r < 90) t = $urandom_range(0, 65535);
        else t = $urandom_range(0, 1) ? 65535 : 0;
        if (t < 0) t = 0;
        if (t > 65535) t = 65535;
        send_word(OpEval, IdxW'($urandom), TempW'($urandom), ValW'($urandom),
                  t[TempW-1:0], 1'b0, NoWant);
      end
    end
    phases_run++;
  endtask

  always @(posedge clk) begin : rx_side
    interp_t head;
    int r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing expected", m_axis_tdata));
      end else begin
        head = pending_results.pop_front();
        results_checked++;
        if (head.status == StBelow) below_seen++;
        if (head.status == StAbove) above_seen++;
        if (head.degen) degen_seen++;
        if (m_axis_tdata[15:0] !== head.value)
          report_mismatch($sformatf("result_value got %0d, want %0d",
                                    $signed(m_axis_tdata[15:0]), $signed(head.value)));
        if (m_axis_tdata[17:16] !== head.status)
          report_mismatch($sformatf("range_status got %0d, want %0d",
                                    m_axis_tdata[17:16], head.status));
        if (m_axis_tdata[18] !== head.degen)
          report_mismatch($sformatf("degenerate_segment got %0b, want %0b",
                                    m_axis_tdata[18], head.degen));
      end
    end
    if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left = HoldCycles - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_eager) begin
      m_axis_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        m_axis_tready <= 1'b1;
      end else if (r < 95) begin
        stall_left = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        stall_left = $urandom_range(15, 50);
        m_axis_tready <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int i, phase, start;
    cur_count = CountW'(2);
    cur_clamp = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < NumDirRows; i++) begin
      case (DirRows[i].kind)
        RowClamp: begin
          wait_idle();
          set_register(CfgClampUnit, DirRows[i].val[CfgDataW-1:0]);
        end
        RowWrite: send_word(OpWrite, DirRows[i].idx, DirRows[i].temp, DirRows[i].val,
                            TempW'($urandom), 1'b0, NoWant);
        default: send_word(OpEval, IdxW'($urandom), TempW'($urandom), ValW'($urandom),
                           DirRows[i].query, DirRows[i].typed, DirRows[i].want);
      endcase
    end

    start = words_sent;
    phase = 0;
    while (words_sent - start < RandomWords) begin
      run_phase(phase);
      phase++;
    end

    rx_eager = 1'b1;
    wait_idle();
    $display("summary: %0d words in (%0d table writes, %0d evaluations) over %0d phases",
             words_sent, writes_sent, evals_sent, phases_run);
    $display("summary: %0d results checked, %0d below, %0d above, %0d zero-width, %0d stall cycles",
             results_checked, below_seen, above_seen, degen_seen, input_stalls);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutCycles * 10);
    $display("tb: failure");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pli_pkg.sv
hw/rtl/pli_div.sv
hw/rtl/piecewise_linear_interpolator_core.sv
bench/piecewise_linear_interpolator_core_test.sv
